### rtl/core/fat12_pkg.sv
// Shared constants and helper functions for the FAT12 directory entry decoder.
`timescale 1ns / 1ps

package fat12_pkg;

    // Scan limits
    localparam int MAX_ENTRIES  = 224;
    localparam int ENTRY_CNT_W  = $clog2(MAX_ENTRIES + 1);

    // Entry layout
    localparam logic [4:0] LAST_POS   = 5'd31;
    localparam logic [4:0] HEAD_LAST  = 5'd17;  // last byte kept in the head buffer
    localparam logic [4:0] SIZE_FIRST = 5'd28;
    localparam int         HEAD_BYTES = 18;
    localparam int         SIZE_LOW_BYTES = 3;  // size bytes 28..30; byte 31 is the last word

    // Attribute bits
    localparam logic [7:0] ATTR_LFN_MASK = 8'h0F;
    localparam logic [7:0] ATTR_VOLUME   = 8'h08;
    localparam logic [7:0] ATTR_DIR      = 8'h10;
    localparam logic [7:0] END_MARK      = 8'h00;

    localparam logic [11:0] YEAR_BASE = 12'd1980;

    // Stream widths
    localparam int RESULT_W = 172;
    localparam int TDATA_W  = 176;

    function automatic logic is_white(input logic [7:0] c);
        is_white = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // Count name bytes ahead of the first whitespace
    function automatic logic [3:0] name_len(input logic [63:0] name);
        logic [3:0] n;
        logic       hit;
        n   = 4'd0;
        hit = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (!hit && is_white(name[8*i +: 8])) begin
                hit = 1'b1;
            end else if (!hit) begin
                n = n + 4'd1;
            end
        end
        name_len = n;
    endfunction

    function automatic logic [1:0] ext_len(input logic [23:0] ext);
        logic [1:0] n;
        logic       hit;
        n   = 2'd0;
        hit = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (!hit && is_white(ext[8*i +: 8])) begin
                hit = 1'b1;
            end else if (!hit) begin
                n = n + 2'd1;
            end
        end
        ext_len = n;
    endfunction

    function automatic logic attr_listed(input logic [7:0] a);
        attr_listed = ((a & ATTR_LFN_MASK) != ATTR_LFN_MASK) &&
                      ((a & ATTR_VOLUME) == 8'h00) &&
                      ((a & ATTR_DIR) == 8'h00);
    endfunction

endpackage

### rtl/core/fat12_root_dir_entry_decoder.sv
// Top level: FAT12 root directory byte stream to listed file records.
`timescale 1ns / 1ps

// FAT12 root directory entry decoder. Feed the raw root directory region one
// byte per word on the s_axis side; set s_axis_tuser on the first byte of a
// scan to clear the counters (reset also starts a scan). Bytes are grouped
// into 32-byte entries. An entry whose first byte is 0x00 ends the scan, as
// does completing MAX_ENTRIES entries; later bytes are dropped until the next
// restart. Entries that are long-name parts, volume labels or directories
// give no word; every other entry gives one record word on m_axis, loaded
// into the output register at the edge that accepts its last byte, so it
// shows on m_axis in the cycle after.
// Throughput is one byte per cycle while m_axis_tready stays high. The input
// side stalls only while a record sits in the output register and
// m_axis_tready is low; the stall lasts until the sink takes that record.
// The record of an entry is built from the bytes held in small capture
// registers plus the final byte, so there is no clearing pass and no
// per-byte latency beyond the single output register.
module fat12_root_dir_entry_decoder
    import fat12_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // data_byte[7:0]
    input  logic                s_axis_tuser,   // restart
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // [7:0] file_index, [71:8] name_chars, [75:72] name_length,
    // [99:76] ext_chars, [101:100] ext_length, [133:102] entry_size,
    // [145:134] year, [149:146] month, [154:150] day, [159:155] hour,
    // [165:160] minute, [171:166] second, [175:172] zero
    output logic [TDATA_W-1:0]  m_axis_tdata
);

    // Scan state
    logic [4:0]             byte_pos_reg,  byte_pos_next;
    logic [ENTRY_CNT_W-1:0] entry_cnt_reg, entry_cnt_next;
    logic [7:0]             listed_cnt_reg, listed_cnt_next;
    logic                   scan_ended_reg, scan_ended_next;

    // Capture registers for the bytes the record needs
    logic [7:0] head_reg [0:HEAD_BYTES-1];
    logic [7:0] size_reg [0:SIZE_LOW_BYTES-1];

    // Output register
    logic               m_valid_reg, m_valid_next;
    logic [TDATA_W-1:0] m_data_reg;

    logic                   s_accept;
    logic [4:0]             byte_pos_eff;
    logic [ENTRY_CNT_W-1:0] entry_cnt_eff, entry_cnt_inc;
    logic [7:0]             listed_eff;
    logic                   ended_eff;
    logic                   end_mark, take, last_byte, out_load;

    logic [63:0] name_w;
    logic [23:0] ext_w;
    logic [15:0] date_w, time_w;
    logic [31:0] size_w;
    logic [RESULT_W-1:0] result_w;

    // Stall only when a finished record is still waiting
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // A restart clears the scan before this byte is looked at
    assign byte_pos_eff  = s_axis_tuser ? 5'd0 : byte_pos_reg;
    assign entry_cnt_eff = s_axis_tuser ? '0 : entry_cnt_reg;
    assign listed_eff    = s_axis_tuser ? 8'd0 : listed_cnt_reg;
    assign ended_eff     = s_axis_tuser ? 1'b0 : scan_ended_reg;
    assign entry_cnt_inc = entry_cnt_eff + 1'b1;

    assign end_mark  = !ended_eff && (byte_pos_eff == 5'd0) && (s_axis_tdata == END_MARK);
    assign take      = !ended_eff && !end_mark;
    assign last_byte = take && (byte_pos_eff == LAST_POS);
    assign out_load  = s_accept && last_byte && attr_listed(head_reg[11]);

    // Assemble the record from captured bytes and the final byte
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            name_w[8*i +: 8] = head_reg[i];
        end
        for (int i = 0; i < 3; i++) begin
            ext_w[8*i +: 8] = head_reg[8 + i];
        end
        time_w   = {head_reg[15], head_reg[14]};
        date_w   = {head_reg[17], head_reg[16]};
        size_w   = {s_axis_tdata, size_reg[2], size_reg[1], size_reg[0]};
        result_w = {time_w[4:0], 1'b0,
                    time_w[10:5],
                    time_w[15:11],
                    date_w[4:0],
                    date_w[8:5],
                    YEAR_BASE + {5'd0, date_w[15:9]},
                    size_w,
                    ext_len(ext_w),
                    ext_w,
                    name_len(name_w),
                    name_w,
                    listed_eff};
    end

    always_comb begin
        byte_pos_next   = byte_pos_reg;
        entry_cnt_next  = entry_cnt_reg;
        listed_cnt_next = listed_cnt_reg;
        scan_ended_next = scan_ended_reg;
        if (s_accept) begin
            byte_pos_next   = byte_pos_eff;
            entry_cnt_next  = entry_cnt_eff;
            listed_cnt_next = listed_eff;
            scan_ended_next = ended_eff;
            if (end_mark) begin
                scan_ended_next = 1'b1;
            end else if (last_byte) begin
                byte_pos_next  = 5'd0;
                entry_cnt_next = entry_cnt_inc;
                if (out_load) begin
                    listed_cnt_next = listed_eff + 8'd1;
                end
                if (entry_cnt_inc == ENTRY_CNT_W'(MAX_ENTRIES)) begin
                    scan_ended_next = 1'b1;
                end
            end else if (take) begin
                byte_pos_next = byte_pos_eff + 5'd1;
            end
        end
    end

    // Hold the record until the sink takes it
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_pos_reg   <= 5'd0;
            entry_cnt_reg  <= '0;
            listed_cnt_reg <= 8'd0;
            scan_ended_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            byte_pos_reg   <= byte_pos_next;
            entry_cnt_reg  <= entry_cnt_next;
            listed_cnt_reg <= listed_cnt_next;
            scan_ended_reg <= scan_ended_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Capture payload bytes; no reset needed
    always_ff @(posedge aclk) begin
        if (s_accept && take && byte_pos_eff <= HEAD_LAST) begin
            head_reg[byte_pos_eff] <= s_axis_tdata;
        end
        if (s_accept && take && byte_pos_eff >= SIZE_FIRST && byte_pos_eff != LAST_POS) begin
            size_reg[byte_pos_eff[1:0]] <= s_axis_tdata;
        end
        if (out_load) begin
            m_data_reg <= {{(TDATA_W - RESULT_W){1'b0}}, result_w};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // A new record appears only right after the last byte of an entry
    a_load_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(s_accept && byte_pos_eff == LAST_POS))
        else $error("record loaded away from the last byte of an entry");

    // An accepted end marker stops the scan
    a_end_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && end_mark) |=> scan_ended_reg)
        else $error("end marker did not stop the scan");

    // The file index advances exactly once per record
    a_index_step: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (listed_cnt_reg == $past(listed_eff) + 8'd1))
        else $error("listed counter out of step with records");

    // Bytes accepted after the scan ended change nothing unless it restarts
    a_hold_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && scan_ended_reg && !s_axis_tuser) |=>
        (byte_pos_reg == $past(byte_pos_reg) && !$rose(m_axis_tvalid)))
        else $error("byte taken after the scan ended");

endmodule
